// ===== rtl/core/ttfd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttfd_pkg
// Types and constants shared by the toxic trade flow detector.
// ----------------------------------------------------------------------------
package ttfd_pkg;

   localparam int SIZE_W = 24;
   localparam int CHG_W  = 32;
   localparam int WIN_W  = 7;

   localparam logic [WIN_W-1:0] WINDOW_RESET = 7'd50;

   typedef struct packed {
      logic [SIZE_W-1:0]        trade_size;
      logic signed [CHG_W-1:0]  price_change;
      logic                     last_of_series;
   } req_type;

   typedef struct packed {
      logic toxic;
      logic window_warm;
   } rsp_type;

endpackage

// ===== rtl/core/toxic_trade_flow_detector.sv =====
// path: an accepted req is held in the input register, and its result in the result register that drives rsp
// throughput: one item per cycle while rsp_stall does not hold the output; the running sums update once per item
// the dropped ring entry is prefetched into a registered read addressed from the next write slot
// reset: synchronous, clears sums, write slot, trade count and window to 50
// ring contents are not reset; only entries written in the current series are read
// ----------------------------------------------------------------------------
// toxic_trade_flow_detector
// Flags trades whose size exceeds twice the window average and whose price
// impact exceeds 1.5 times the window average, over a sliding window.
// ----------------------------------------------------------------------------
module toxic_trade_flow_detector #(
   parameter int MAX_WINDOW = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  ttfd_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output ttfd_pkg::rsp_type           rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [ttfd_pkg::WIN_W-1:0]  csr_data
);
   import ttfd_pkg::*;

   localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int AW       = SLOT_W + 1;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
   localparam int SSUM_W   = SIZE_W + SLOT_W;
   localparam int ISUM_W   = CHG_W + SLOT_W;
   localparam int SPROD_W  = SIZE_W + WIN_W;
   localparam int IPROD_W  = CHG_W + WIN_W + 1;
   localparam int SCMP_W   = (SPROD_W > SSUM_W + 1) ? SPROD_W : SSUM_W + 1;
   localparam int ICMP_W   = (IPROD_W > ISUM_W + 2) ? IPROD_W : ISUM_W + 2;

   function automatic logic [WIN_W-1:0] clamp_window(input logic [WIN_W-1:0] v);
      logic [WIN_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = WIN_W'(1);
      end else if (32'(v) > MAX_WINDOW) begin
         r = WIN_W'(MAX_WINDOW);
      end
      return r;
   endfunction

   logic [SIZE_W-1:0]  size_ring [MAX_WINDOW];
   logic [CHG_W-1:0]   impact_ring [MAX_WINDOW];

   logic               in_valid_ff, in_valid_in;
   req_type            in_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic [WIN_W-1:0]   window_ff, window_in;
   logic [SSUM_W-1:0]  ssum_ff, ssum_in;
   logic [ISUM_W-1:0]  isum_ff, isum_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [SIZE_W-1:0]  old_size_ff;
   logic [CHG_W-1:0]   old_mag_ff;

   logic               out_free, fire, accept, warm, big, hit;
   logic [WIN_W-1:0]   w_cur, w_next;
   logic [CHG_W-1:0]   mag;
   logic [SSUM_W-1:0]  ssum_new;
   logic [ISUM_W-1:0]  isum_new;
   logic [SPROD_W-1:0] sprod;
   logic [IPROD_W-1:0] iprod;
   logic [ICMP_W-1:0]  isum3;
   logic [AW-1:0]      rd_sum, rd_wrap;
   logic [SLOT_W-1:0]  rd_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      w_cur    = clamp_window(window_ff);
      warm     = CMP_W'(seen_ff) >= CMP_W'(w_cur);
      mag      = in_ff.price_change[CHG_W-1] ? (~in_ff.price_change + 1'b1)
                                              : in_ff.price_change;
      ssum_new = (warm ? (ssum_ff - SSUM_W'(old_size_ff)) : ssum_ff)
                 + SSUM_W'(in_ff.trade_size);
      isum_new = (warm ? (isum_ff - ISUM_W'(old_mag_ff)) : isum_ff)
                 + ISUM_W'(mag);
      sprod    = SPROD_W'(in_ff.trade_size) * SPROD_W'(w_cur);
      iprod    = {(IPROD_W-1)'((IPROD_W-1)'(mag) * (IPROD_W-1)'(w_cur)), 1'b0};
      isum3    = ICMP_W'(isum_new) + ICMP_W'({isum_new, 1'b0});
      big      = SCMP_W'(sprod) > SCMP_W'({ssum_new, 1'b0});
      hit      = ICMP_W'(iprod) > isum3;

      in_valid_in = accept ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
      rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
      rsp_data_in.toxic       = warm && big && hit;
      rsp_data_in.window_warm = warm;

      window_in = csr_valid ? csr_data : window_ff;
      ssum_in   = ssum_ff;
      isum_in   = isum_ff;
      slot_in   = slot_ff;
      seen_in   = seen_ff;
      if (csr_valid) begin
         ssum_in = '0;
         isum_in = '0;
         slot_in = '0;
         seen_in = '0;
      end else if (fire) begin
         if (in_ff.last_of_series) begin
            ssum_in = '0;
            isum_in = '0;
            slot_in = '0;
            seen_in = '0;
         end else begin
            ssum_in = ssum_new;
            isum_in = isum_new;
            slot_in = (32'(slot_ff) == MAX_WINDOW - 1) ? '0 : slot_ff + 1'b1;
            seen_in = (32'(seen_ff) < MAX_WINDOW) ? seen_ff + 1'b1 : seen_ff;
         end
      end

      w_next  = clamp_window(window_in);
      rd_sum  = AW'(slot_in) + AW'(MAX_WINDOW) - AW'(w_next);
      rd_wrap = (32'(rd_sum) >= MAX_WINDOW) ? rd_sum - AW'(MAX_WINDOW) : rd_sum;
      rd_addr = rd_wrap[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= WINDOW_RESET;
         ssum_ff      <= '0;
         isum_ff      <= '0;
         slot_ff      <= '0;
         seen_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         window_ff    <= window_in;
         ssum_ff      <= ssum_in;
         isum_ff      <= isum_in;
         slot_ff      <= slot_in;
         seen_ff      <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // ring write with prefetch of the entry that leaves the window next
   always_ff @(posedge clock) begin
      if (fire) begin
         size_ring[slot_ff]   <= in_ff.trade_size;
         impact_ring[slot_ff] <= mag;
      end
      if (fire && rd_addr == slot_ff) begin
         old_size_ff <= in_ff.trade_size;
         old_mag_ff  <= mag;
      end else begin
         old_size_ff <= size_ring[rd_addr];
         old_mag_ff  <= impact_ring[rd_addr];
      end
   end

   a_csr_clears: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> (seen_ff == '0 && slot_ff == '0 && ssum_ff == '0))
      else $error("csr write did not clear series state");

   a_toxic_warm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.toxic || rsp_data_ff.window_warm))
      else $error("toxic flagged before window warm");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_ff)))
      else $error("input stage changed while blocked");

   a_cold_count: assert property (@(posedge clock) disable iff (reset)
      (fire && !warm && !csr_valid && !in_ff.last_of_series) |=> seen_ff == $past(seen_ff) + 1'b1)
      else $error("trade count did not advance while window cold");

endmodule
